/* rtl/core/lbpm_pkg.sv */
package lbpm_pkg;

	localparam int LogSlots  = 16;
	localparam int MaxBudget = 16;
	localparam int SlotW     = (LogSlots > 1) ? $clog2(LogSlots) : 1;
	localparam int ResW      = $clog2(MaxBudget + 1);
	localparam int BufW      = (MaxBudget > 1) ? $clog2(MaxBudget) : 1;
	localparam int PageW     = 32;
	localparam int PpbW      = 13;
	localparam int CntW      = 16;
	localparam int KindW     = 3;
	localparam int SlotOutW  = 6;
	localparam int BudgetW   = 5;
	localparam int DivCntW   = $clog2(PageW);

	localparam logic [CntW-1:0] CntMax = '1;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_TRIM  = 2'd1,
		OP_MERGE = 2'd2,
		OP_NONE  = 2'd3
	} opcode_t;

	typedef enum logic [KindW-1:0] {
		KIND_TRACKED   = 3'd0,
		KIND_UNTRACKED = 3'd1,
		KIND_TRIM      = 3'd2,
		KIND_SWITCH    = 3'd3,
		KIND_FULL      = 3'd4,
		KIND_NO_VICTIM = 3'd5
	} kind_t;

	typedef enum logic [0:0] {
		REG_PPB    = 1'b0,
		REG_BLOCKS = 1'b1
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV,
		ST_FIND,
		ST_UPD,
		ST_MSCAN,
		ST_MPICK,
		ST_RSCAN,
		ST_ORD,
		ST_OWAIT
	} state_t;

	typedef struct packed {
		kind_t             kind;
		logic [PageW-1:0]  blk;
		logic [SlotW-1:0]  slot;
	} res_t;

endpackage

/* rtl/core/log_block_pool_merge_manager.sv */
// Log-block slot manager: one item in at a time, in_stall is high while it works. A write or
// trim does a bit-serial divide of the page by pages_per_block, one pass over the 16 slots to
// find or claim, an update step and one pass to work out reclaim, then sends its result beat.
// A merge request makes one slot pass per victim, then the reclaim pass and the result beats.
// All merge results are held in a small result buffer until reclaim is known, then leave one
// at a time, each held while out_stall is high.
module log_block_pool_merge_manager (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        opcode,
	input  logic [lbpm_pkg::PageW-1:0]        page_number,
	input  logic [lbpm_pkg::BudgetW-1:0]      merge_budget,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [lbpm_pkg::KindW-1:0]        result_kind,
	output logic [lbpm_pkg::PageW-1:0]        block_number,
	output logic [lbpm_pkg::SlotOutW-1:0]     slot_index,
	output logic                              reclaim_needed,
	output logic                              last,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic                              cfg_index,
	input  logic [31:0]                       cfg_data
);

	lbpm_pkg::state_t st_q, st_nx;

	logic [lbpm_pkg::PpbW-1:0]   ppb_q;
	logic [lbpm_pkg::PageW-1:0]  bcnt_q;
	logic [lbpm_pkg::PpbW-1:0]   ppb_eff;

	lbpm_pkg::opcode_t           op_q;
	logic [lbpm_pkg::ResW-1:0]   budget_q;
	logic [lbpm_pkg::ResW-1:0]   n_q;
	logic [lbpm_pkg::BufW-1:0]   rd_q;
	logic [lbpm_pkg::PageW-1:0]  blk_q;
	logic [lbpm_pkg::PpbW-1:0]   off_q;
	logic [lbpm_pkg::SlotW-1:0]  idx_q;

	logic                        hit_q, free_q;
	logic [lbpm_pkg::SlotW-1:0]  hit_idx_q, free_idx_q;
	logic [lbpm_pkg::CntW-1:0]   hit_used_q, hit_seq_q;

	logic                        vfound_q;
	logic [lbpm_pkg::SlotW-1:0]  vidx_q;
	logic [lbpm_pkg::CntW-1:0]   vused_q, vseq_q;
	logic [lbpm_pkg::PageW-1:0]  vblk_q;

	logic                        rfull_q, rfree_q;

	logic [lbpm_pkg::LogSlots-1:0] busy_q;
	logic [lbpm_pkg::PageW-1:0]    sblk_q  [lbpm_pkg::LogSlots];
	logic [lbpm_pkg::CntW-1:0]     sused_q [lbpm_pkg::LogSlots];
	logic [lbpm_pkg::CntW-1:0]     sseq_q  [lbpm_pkg::LogSlots];

	lbpm_pkg::res_t              rbuf_q [lbpm_pkg::MaxBudget];

	logic                        out_v_q;
	lbpm_pkg::res_t              out_q;
	logic                        out_rc_q, out_last_q;

	logic                        div_start, div_done;
	logic [lbpm_pkg::PageW-1:0]  div_quot;
	logic [lbpm_pkg::PpbW-1:0]   div_rem;

	logic                        in_acc, scan_end, in_range, tracked;
	logic [lbpm_pkg::SlotW-1:0]  wr_slot;
	logic [lbpm_pkg::CntW-1:0]   cur_used, cur_seq;
	logic [lbpm_pkg::ResW-1:0]   n_inc;
	logic                        rd_last;
	logic                        rd_busy;
	logic [lbpm_pkg::PageW-1:0]  rd_blk;
	logic [lbpm_pkg::CntW-1:0]   rd_used, rd_seq;
	logic [lbpm_pkg::ResW-1:0]   budget_in;

	function automatic logic [lbpm_pkg::CntW-1:0] CntW16(input logic [lbpm_pkg::PpbW-1:0] v);
		CntW16 = lbpm_pkg::CntW'(v);
	endfunction

	assign ppb_eff  = (ppb_q == '0) ? lbpm_pkg::PpbW'(1) : ppb_q;
	assign in_acc   = in_valid && !in_stall;
	assign scan_end = idx_q == lbpm_pkg::SlotW'(lbpm_pkg::LogSlots - 1);
	assign in_range = blk_q < bcnt_q;
	assign tracked  = in_range && (hit_q || free_q);
	assign wr_slot  = hit_q ? hit_idx_q : free_idx_q;
	assign cur_used = hit_q ? hit_used_q : '0;
	assign cur_seq  = hit_q ? hit_seq_q : '0;
	assign n_inc    = n_q + 1'b1;
	assign rd_last  = lbpm_pkg::ResW'(rd_q) + lbpm_pkg::ResW'(1) == n_q;
	assign rd_busy  = busy_q[idx_q];
	assign rd_blk   = sblk_q[idx_q];
	assign rd_used  = sused_q[idx_q];
	assign rd_seq   = sseq_q[idx_q];
	assign budget_in = (merge_budget == '0) ? lbpm_pkg::ResW'(1) :
		(32'(merge_budget) > lbpm_pkg::MaxBudget) ? lbpm_pkg::ResW'(lbpm_pkg::MaxBudget) :
		lbpm_pkg::ResW'(merge_budget);

	lbpm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (page_number),
		.divisor  (ppb_eff),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	always_comb begin
		st_nx = st_q;
		case (st_q)
			lbpm_pkg::ST_IDLE: begin
				if (in_acc) begin
					case (opcode)
						lbpm_pkg::OP_WRITE, lbpm_pkg::OP_TRIM: st_nx = lbpm_pkg::ST_DIV;
						lbpm_pkg::OP_MERGE: st_nx = lbpm_pkg::ST_MSCAN;
						default: st_nx = lbpm_pkg::ST_IDLE;
					endcase
				end
			end
			lbpm_pkg::ST_DIV:   if (div_done) st_nx = lbpm_pkg::ST_FIND;
			lbpm_pkg::ST_FIND:  if (scan_end) st_nx = lbpm_pkg::ST_UPD;
			lbpm_pkg::ST_UPD:   st_nx = lbpm_pkg::ST_RSCAN;
			lbpm_pkg::ST_MSCAN: if (scan_end) st_nx = lbpm_pkg::ST_MPICK;
			lbpm_pkg::ST_MPICK: begin
				if (vfound_q && n_inc != budget_q) st_nx = lbpm_pkg::ST_MSCAN;
				else st_nx = lbpm_pkg::ST_RSCAN;
			end
			lbpm_pkg::ST_RSCAN: if (scan_end) st_nx = lbpm_pkg::ST_ORD;
			lbpm_pkg::ST_ORD:   st_nx = lbpm_pkg::ST_OWAIT;
			lbpm_pkg::ST_OWAIT: begin
				if (!out_stall) st_nx = rd_last ? lbpm_pkg::ST_IDLE : lbpm_pkg::ST_ORD;
			end
			default: st_nx = lbpm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall  = st_q != lbpm_pkg::ST_IDLE;
		div_start = (st_q == lbpm_pkg::ST_IDLE) && in_acc &&
			(opcode == lbpm_pkg::OP_WRITE || opcode == lbpm_pkg::OP_TRIM);
		cfg_ready = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= lbpm_pkg::ST_IDLE;
			ppb_q   <= lbpm_pkg::PpbW'(256);
			bcnt_q  <= 32'd65536;
			busy_q  <= '0;
			out_v_q <= 1'b0;
		end else begin
			st_q <= st_nx;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					lbpm_pkg::REG_PPB:    ppb_q  <= cfg_data[lbpm_pkg::PpbW-1:0];
					lbpm_pkg::REG_BLOCKS: bcnt_q <= cfg_data;
					default: ;
				endcase
			end
			case (st_q)
				lbpm_pkg::ST_UPD: begin
					if (op_q == lbpm_pkg::OP_WRITE && tracked) busy_q[wr_slot] <= 1'b1;
				end
				lbpm_pkg::ST_MPICK: begin
					if (vfound_q) busy_q[vidx_q] <= 1'b0;
				end
				lbpm_pkg::ST_ORD:   out_v_q <= 1'b1;
				lbpm_pkg::ST_OWAIT: if (!out_stall) out_v_q <= 1'b0;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			lbpm_pkg::ST_IDLE: begin
				op_q     <= lbpm_pkg::opcode_t'(opcode);
				budget_q <= budget_in;
				n_q      <= '0;
				idx_q    <= '0;
				vfound_q <= 1'b0;
			end
			lbpm_pkg::ST_DIV: begin
				blk_q  <= div_quot;
				off_q  <= div_rem;
				idx_q  <= '0;
				hit_q  <= 1'b0;
				free_q <= 1'b0;
			end
			lbpm_pkg::ST_FIND: begin
				if (rd_busy && rd_blk == blk_q && !hit_q) begin
					hit_q      <= 1'b1;
					hit_idx_q  <= idx_q;
					hit_used_q <= rd_used;
					hit_seq_q  <= rd_seq;
				end
				if (!rd_busy && !free_q) begin
					free_q     <= 1'b1;
					free_idx_q <= idx_q;
				end
				idx_q <= idx_q + 1'b1;
			end
			lbpm_pkg::ST_UPD: begin
				if (op_q == lbpm_pkg::OP_WRITE) begin
					if (tracked) begin
						sblk_q[wr_slot]  <= blk_q;
						sseq_q[wr_slot]  <= (cur_used == CntW16(off_q) && cur_seq != lbpm_pkg::CntMax)
							? cur_seq + 1'b1 : cur_seq;
						sused_q[wr_slot] <= (cur_used != lbpm_pkg::CntMax) ? cur_used + 1'b1 : cur_used;
						rbuf_q[0] <= '{lbpm_pkg::KIND_TRACKED, blk_q, wr_slot};
					end else begin
						rbuf_q[0] <= '{lbpm_pkg::KIND_UNTRACKED, blk_q, '0};
					end
				end else begin
					if (in_range && hit_q && hit_used_q != '0)
						sused_q[hit_idx_q] <= hit_used_q - 1'b1;
					rbuf_q[0] <= '{lbpm_pkg::KIND_TRIM, blk_q,
						(in_range && hit_q) ? hit_idx_q : '0};
				end
				n_q     <= lbpm_pkg::ResW'(1);
				idx_q   <= '0;
				rfull_q <= 1'b0;
				rfree_q <= 1'b0;
			end
			lbpm_pkg::ST_MSCAN: begin
				if (rd_busy && (!vfound_q || rd_used > vused_q)) begin
					vfound_q <= 1'b1;
					vidx_q   <= idx_q;
					vused_q  <= rd_used;
					vseq_q   <= rd_seq;
					vblk_q   <= rd_blk;
				end
				idx_q <= idx_q + 1'b1;
			end
			lbpm_pkg::ST_MPICK: begin
				if (vfound_q) begin
					rbuf_q[n_q[lbpm_pkg::BufW-1:0]] <= '{
						(vseq_q >= CntW16(ppb_eff)) ? lbpm_pkg::KIND_SWITCH : lbpm_pkg::KIND_FULL,
						vblk_q, vidx_q};
					n_q <= n_inc;
				end else if (n_q == '0) begin
					rbuf_q[0] <= '{lbpm_pkg::KIND_NO_VICTIM, '0, '0};
					n_q       <= lbpm_pkg::ResW'(1);
				end
				idx_q    <= '0;
				vfound_q <= 1'b0;
				rfull_q  <= 1'b0;
				rfree_q  <= 1'b0;
			end
			lbpm_pkg::ST_RSCAN: begin
				if (rd_busy && rd_used >= CntW16(ppb_eff)) rfull_q <= 1'b1;
				if (!rd_busy) rfree_q <= 1'b1;
				idx_q <= idx_q + 1'b1;
				rd_q  <= '0;
			end
			lbpm_pkg::ST_ORD: begin
				out_q      <= rbuf_q[rd_q];
				out_rc_q   <= rfull_q || !rfree_q;
				out_last_q <= rd_last;
			end
			lbpm_pkg::ST_OWAIT: begin
				if (!out_stall && !rd_last) rd_q <= rd_q + 1'b1;
			end
			default: ;
		endcase
	end

	assign out_valid      = out_v_q;
	assign result_kind    = out_q.kind;
	assign block_number   = out_q.blk;
	assign slot_index     = lbpm_pkg::SlotOutW'(out_q.slot);
	assign reclaim_needed = out_rc_q;
	assign last           = out_last_q;

	a_out_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> st_q == lbpm_pkg::ST_OWAIT)
		else $error("result beat outside output wait");

	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && last) |=> st_q == lbpm_pkg::ST_IDLE)
		else $error("no return to idle after final beat");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> st_q == lbpm_pkg::ST_DIV)
		else $error("divider finished outside divide state");

	a_res_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == lbpm_pkg::ST_ORD) |-> (n_q != '0 && n_q <= budget_q + 1'b1))
		else $error("result count out of range");

endmodule

/* rtl/core/lbpm_div.sv */
module lbpm_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [lbpm_pkg::PageW-1:0]  dividend,
	input  logic [lbpm_pkg::PpbW-1:0]   divisor,
	output logic                        done,
	output logic [lbpm_pkg::PageW-1:0]  quot,
	output logic [lbpm_pkg::PpbW-1:0]   rem
);

	logic                          busy_q;
	logic                          done_q;
	logic [lbpm_pkg::DivCntW-1:0]  cnt_q;
	logic [lbpm_pkg::PageW-1:0]    q_q;
	logic [lbpm_pkg::PpbW-1:0]     r_q;
	logic [lbpm_pkg::PpbW-1:0]     d_q;
	logic [lbpm_pkg::PpbW:0]       trial;
	logic                          take;

	assign trial = {r_q, q_q[lbpm_pkg::PageW-1]};
	assign take  = trial >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == lbpm_pkg::DivCntW'(lbpm_pkg::PageW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (busy_q) begin
			q_q <= {q_q[lbpm_pkg::PageW-2:0], take};
			r_q <= take ? lbpm_pkg::PpbW'(trial - {1'b0, d_q}) : trial[lbpm_pkg::PpbW-1:0];
		end
	end

	assign done = done_q;
	assign quot = q_q;
	assign rem  = r_q;

endmodule
